// ===== src/trm_pkg.sv =====
// Shared types and codes of the tiny register machine step block.
// Used by the top level; depends on nothing.
package trm_pkg;

	localparam int unsigned MaxLinesDefault = 256;

	localparam int unsigned DataW = 16;
	localparam int unsigned LenW  = 9;

	localparam logic [2:0] OP_MOV = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_SUB = 3'd2;
	localparam logic [2:0] OP_PUT = 3'd3;
	localparam logic [2:0] OP_JMP = 3'd4;
	localparam logic [2:0] OP_JMA = 3'd5;
	localparam logic [2:0] OP_JMC = 3'd6;

	localparam logic [2:0] SRC_A   = 3'd0;
	localparam logic [2:0] SRC_B   = 3'd1;
	localparam logic [2:0] SRC_T   = 3'd2;
	localparam logic [2:0] SRC_IMM = 3'd3;

	localparam logic [2:0] DST_A = 3'd0;
	localparam logic [2:0] DST_B = 3'd1;
	localparam logic [2:0] DST_T = 3'd2;

	typedef logic [LenW-1:0] prog_len_t;

	typedef struct packed {
		logic [2:0]              opcode;
		logic [2:0]              first_source;
		logic [2:0]              second_source;
		logic [2:0]              destination;
		logic signed [DataW-1:0] immediate;
	} instr_t;

	typedef struct packed {
		logic signed [DataW-1:0] next_line;
		logic                    print_valid;
		logic signed [DataW-1:0] print_value;
		logic                    finished;
	} result_t;

endpackage

// ===== src/trm_stream_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; the block uses trm_pkg types for it.
interface trm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tiny_register_machine_step.sv =====
// Executes one fetched instruction per item on three 16-bit registers (A, B, T)
// and a signed 16-bit line counter, returning one result per instruction.
// Depends on trm_pkg and trm_stream_if.
//
// One instruction is accepted every clock cycle when the result side keeps up;
// each goes through the input register, then is executed into the result
// register. The rate is set by the loop that reads and writes the register
// file and line counter in the execute stage. program_length is to be written
// on cfg only while no instruction is in flight; the block does not enforce it.
// Reset value is zero; clamped to MAX_LINES for the jma clamp and finished flag.
module tiny_register_machine_step
	import trm_pkg::*;
#(
	parameter int unsigned MAX_LINES = MaxLinesDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	trm_stream_if.sink       instr,
	trm_stream_if.source     result,
	trm_stream_if.sink       cfg
);

	localparam logic [DataW-1:0] MaxLinesW = DataW'(MAX_LINES);

	logic                    instr_valid_s1;
	instr_t                  instr_s1;
	logic                    out_valid_q;
	result_t                 out_q;
	logic [DataW-1:0]        reg_a_q, reg_b_q, reg_t_q;
	logic signed [DataW-1:0] line_q;
	prog_len_t               prog_len_q;

	logic                    exec;
	logic [DataW-1:0]        len_ext, eff_len;
	logic [DataW-1:0]        op1, op2, alu, line_inc;
	logic signed [DataW:0]   jma_sum;
	logic [DataW:0]          jma_pc;
	logic signed [DataW-1:0] next_line;
	logic                    wr_en;
	result_t                 res;

	assign exec        = instr_valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !instr_valid_s1 || exec;
	assign cfg.ready   = 1'b1;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	function automatic logic [DataW-1:0] pick(input logic [2:0] code,
		input logic [DataW-1:0] a, input logic [DataW-1:0] b,
		input logic [DataW-1:0] t, input logic [DataW-1:0] imm);
		logic [DataW-1:0] v;
		case (code)
			SRC_A:   v = a;
			SRC_B:   v = b;
			SRC_T:   v = t;
			SRC_IMM: v = imm;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		len_ext  = DataW'(prog_len_q);
		eff_len  = (len_ext > MaxLinesW) ? MaxLinesW : len_ext;
		op1      = pick(instr_s1.first_source, reg_a_q, reg_b_q, reg_t_q,
			instr_s1.immediate);
		op2      = pick(instr_s1.second_source, reg_a_q, reg_b_q, reg_t_q,
			instr_s1.immediate);
		line_inc = line_q + 1'b1;

		// jma: exact sum, clamp to 0..length, then step
		jma_sum = $signed({line_q[DataW-1], line_q}) + $signed({op1[DataW-1], op1});
		if (jma_sum[DataW])
			jma_pc = '0;
		else if (jma_sum[DataW-1:0] > eff_len)
			jma_pc = {1'b0, eff_len};
		else
			jma_pc = jma_sum;

		alu       = op1;
		wr_en     = 1'b0;
		next_line = line_inc;
		res       = '0;
		case (instr_s1.opcode)
			OP_MOV: begin
				alu   = op1;
				wr_en = 1'b1;
			end
			OP_ADD: begin
				alu   = op1 + op2;
				wr_en = 1'b1;
			end
			OP_SUB: begin
				alu   = op1 - op2;
				wr_en = 1'b1;
			end
			OP_PUT: begin
				res.print_valid = 1'b1;
				res.print_value = op1;
			end
			OP_JMP: next_line = instr_s1.immediate;
			OP_JMA: next_line = DataW'(jma_pc + 1'b1);
			OP_JMC: begin
				if ($signed(reg_t_q) > 0)
					next_line = instr_s1.immediate;
			end
			default: ;
		endcase

		res.next_line = next_line;
		res.finished  = next_line[DataW-1] || (next_line >= $signed(eff_len));
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			instr_valid_s1 <= 1'b0;
		else if (instr.valid && instr.ready)
			instr_valid_s1 <= 1'b1;
		else if (exec)
			instr_valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready)
			instr_s1 <= instr.data;
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (exec)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec)
			out_q <= res;
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_a_q <= '0;
			reg_b_q <= '0;
			reg_t_q <= '0;
			line_q  <= '0;
		end else if (exec) begin
			line_q <= next_line;
			if (wr_en) begin
				case (instr_s1.destination)
					DST_A:   reg_a_q <= alu;
					DST_B:   reg_b_q <= alu;
					DST_T:   reg_t_q <= alu;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prog_len_q <= '0;
		else if (cfg.valid && cfg.ready)
			prog_len_q <= cfg.data;
	end

	// The shown result always carries the current line counter
	a_line_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.next_line == line_q))
		else $error("result next_line differs from line counter");

	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.print_valid) |-> (out_q.print_value == '0))
		else $error("print_value set without print_valid");

	a_jmp_target: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && instr_s1.opcode == OP_JMP) |=> (line_q == $past(instr_s1.immediate)))
		else $error("jmp did not load the line counter");

	a_one_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && !(instr.valid && instr.ready)) |=> !instr_valid_s1)
		else $error("executed item left in input stage");

endmodule
